[hw/rtl/kts_pkg.sv]
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants of the keyword table scanner.
// ----------------------------------------------------------------------------
package kts_pkg;

    // keyword table geometry
    localparam int unsigned NUM_KW      = 8;
    localparam int unsigned KW_LEN      = 16;
    localparam int unsigned SLOT_W      = 3;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned CNT_W       = 4;

    // run position counter, saturating
    localparam int unsigned BUF_W       = 15;
    localparam logic [BUF_W-1:0] MAX_BUF_LEN = 15'd32767;

    // bytes below this code leave as zero
    localparam logic [7:0] CTRL_LIMIT   = 8'd27;
    localparam logic [7:0] NULL_BYTE    = 8'h00;

    // result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // item function codes
    typedef enum logic [1:0] {
        FN_CHAR = 2'd0,
        FN_LEN  = 2'd1,
        FN_BYTE = 2'd2
    } t_func;

    typedef logic [KW_LEN-1:0][7:0] t_kw_row;

    // keyword table write request
    typedef struct packed {
        logic              chr_we;
        logic              len_we;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos;
        logic [7:0]        data;
    } t_kw_wr;

    // report sequencer status towards the input stage
    typedef struct packed {
        logic busy;
        logic out_free;
        logic clear;
    } t_rep_stat;

endpackage

[hw/rtl/kts_kw_store.sv]
// ----------------------------------------------------------------------------
// kts_kw_store
// Keyword character cells and keyword lengths, one row of cells per slot.
// ----------------------------------------------------------------------------
module kts_kw_store (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  kts_pkg::t_kw_wr                        i_wr,
    output kts_pkg::t_kw_row                       o_chars [kts_pkg::NUM_KW],
    output logic [kts_pkg::LEN_W-1:0]              o_lens  [kts_pkg::NUM_KW]
);

    kts_pkg::t_kw_row                r_chars [kts_pkg::NUM_KW];
    logic [kts_pkg::LEN_W-1:0]       r_lens  [kts_pkg::NUM_KW];
    logic [kts_pkg::LEN_W-1:0]       n_len;

    // lengths above the cell count saturate
    always_comb begin
        if (i_wr.data > 8'(kts_pkg::KW_LEN)) begin
            n_len = kts_pkg::LEN_W'(kts_pkg::KW_LEN);
        end else begin
            n_len = i_wr.data[kts_pkg::LEN_W-1:0];
        end
    end

    // character cells, written only when loaded
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < kts_pkg::NUM_KW; i++) begin
            if (i_wr.chr_we && i_wr.slot == kts_pkg::SLOT_W'(i)) begin
                r_chars[i][i_wr.pos] <= i_wr.data;
            end
        end
    end

    // length registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kts_pkg::NUM_KW; i++) begin
                r_lens[i] <= '0;
            end
        end else begin
            for (int i = 0; i < kts_pkg::NUM_KW; i++) begin
                if (i_wr.len_we && i_wr.slot == kts_pkg::SLOT_W'(i)) begin
                    r_lens[i] <= n_len;
                end
            end
        end
    end

    assign o_chars = r_chars;
    assign o_lens  = r_lens;

endmodule

[hw/rtl/kts_match.sv]
// ----------------------------------------------------------------------------
// kts_match
// Byte window, run position and per-keyword first-match tracking.
// ----------------------------------------------------------------------------
module kts_match (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic                             i_clear,
    input  logic [7:0]                       i_byte,
    input  kts_pkg::t_kw_row                 i_chars [kts_pkg::NUM_KW],
    input  logic [kts_pkg::LEN_W-1:0]        i_lens  [kts_pkg::NUM_KW],
    output logic [kts_pkg::NUM_KW-1:0]       o_found,
    output logic [kts_pkg::NUM_KW-1:0]       o_found_nxt,
    output logic [kts_pkg::BUF_W-1:0]        o_ends  [kts_pkg::NUM_KW]
);

    logic [7:0]                      r_win  [kts_pkg::KW_LEN];
    logic [7:0]                      n_win  [kts_pkg::KW_LEN];
    logic [kts_pkg::BUF_W-1:0]       r_seen;
    logic [kts_pkg::BUF_W-1:0]       n_seen;
    logic [kts_pkg::NUM_KW-1:0]      r_found;
    logic [kts_pkg::NUM_KW-1:0]      n_found;
    logic [kts_pkg::BUF_W-1:0]       r_ends [kts_pkg::NUM_KW];
    logic [kts_pkg::BUF_W-1:0]       n_ends [kts_pkg::NUM_KW];
    logic [kts_pkg::KW_LEN-1:0]      cell_ok [kts_pkg::NUM_KW];
    logic [kts_pkg::NUM_KW-1:0]      hit;

    // window after this beat's byte is shifted in
    always_comb begin
        n_win[0] = i_byte;
        for (int k = 1; k < kts_pkg::KW_LEN; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    // saturating position count
    assign n_seen = (r_seen == kts_pkg::MAX_BUF_LEN) ? r_seen : r_seen + 1'b1;

    // every keyword against the tail of the window, all cells in parallel
    always_comb begin
        for (int i = 0; i < kts_pkg::NUM_KW; i++) begin
            for (int j = 0; j < kts_pkg::KW_LEN; j++) begin
                if (kts_pkg::LEN_W'(j) < i_lens[i]) begin
                    cell_ok[i][j] = i_chars[i][j] ==
                        n_win[kts_pkg::POS_W'(i_lens[i] - kts_pkg::LEN_W'(j) - 1'b1)];
                end else begin
                    cell_ok[i][j] = 1'b1;
                end
            end
            hit[i] = (i_lens[i] == '0) ||
                     ((kts_pkg::BUF_W'(i_lens[i]) <= n_seen) && (&cell_ok[i]));
            n_found[i] = r_found[i] | hit[i];
            if (r_found[i]) begin
                n_ends[i] = r_ends[i];
            end else if (i_lens[i] == '0) begin
                n_ends[i] = '0;
            end else begin
                n_ends[i] = n_seen;
            end
        end
    end

    // window and first-match offsets
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_win  <= n_win;
            r_ends <= n_ends;
        end
    end

    // run control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_seen  <= '0;
            r_found <= '0;
        end else if (i_step) begin
            r_seen  <= n_seen;
            r_found <= n_found;
        end
    end

    assign o_found     = r_found;
    assign o_found_nxt = n_found;
    assign o_ends      = r_ends;

endmodule

[hw/rtl/kts_report.sv]
// ----------------------------------------------------------------------------
// kts_report
// Result register and end-of-run report sequencer.
// ----------------------------------------------------------------------------
module kts_report (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic [7:0]                       i_byte,
    input  logic                             i_last,
    input  logic [kts_pkg::CNT_W-1:0]        i_active,
    input  logic [kts_pkg::NUM_KW-1:0]       i_found,
    input  logic [kts_pkg::NUM_KW-1:0]       i_found_nxt,
    input  logic [kts_pkg::BUF_W-1:0]        i_ends [kts_pkg::NUM_KW],
    input  logic                             i_out_ready,
    output kts_pkg::t_rep_stat               o_stat,
    output logic                             o_out_valid,
    output logic                             o_kind,
    output logic [7:0]                       o_clean_byte,
    output logic [kts_pkg::SLOT_W-1:0]       o_report_index,
    output logic                             o_found,
    output logic [kts_pkg::BUF_W-1:0]        o_match_end,
    output logic [kts_pkg::CNT_W-1:0]        o_found_count,
    output logic                             o_last_result
);

    logic                            r_busy;
    logic [kts_pkg::SLOT_W-1:0]      r_idx;
    logic [kts_pkg::CNT_W-1:0]       r_count;
    logic [kts_pkg::CNT_W-1:0]       n_count;
    logic                            r_valid;
    logic                            r_kind;
    logic [7:0]                      r_clean;
    logic [kts_pkg::SLOT_W-1:0]      r_rep_idx;
    logic                            r_fnd;
    logic [kts_pkg::BUF_W-1:0]       r_end;
    logic [kts_pkg::CNT_W-1:0]       r_cnt;
    logic                            r_last;
    logic                            out_free;
    logic                            rep_load;
    logic                            rep_final;
    logic                            run_end;
    logic [kts_pkg::SLOT_W-1:0]      last_idx;

    assign out_free  = !r_valid || i_out_ready;
    assign last_idx  = kts_pkg::SLOT_W'(i_active - 1'b1);
    assign rep_load  = r_busy && out_free;
    assign rep_final = rep_load && (r_idx == last_idx);
    assign run_end   = i_step && i_last;

    // keywords found among the active slots, after this beat
    always_comb begin
        n_count = '0;
        for (int i = 0; i < kts_pkg::NUM_KW; i++) begin
            if (kts_pkg::CNT_W'(i) < i_active && i_found_nxt[i]) begin
                n_count = n_count + 1'b1;
            end
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (run_end && i_active != '0) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (rep_final) begin
            r_busy <= 1'b0;
        end else if (rep_load) begin
            r_idx  <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (run_end) begin
            r_count <= n_count;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step || rep_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_kind    <= kts_pkg::KIND_BYTE;
            r_clean   <= (i_byte < kts_pkg::CTRL_LIMIT) ? kts_pkg::NULL_BYTE : i_byte;
            r_rep_idx <= '0;
            r_fnd     <= 1'b0;
            r_end     <= '0;
            r_cnt     <= '0;
            r_last    <= i_last && (i_active == '0);
        end else if (rep_load) begin
            r_kind    <= kts_pkg::KIND_REPORT;
            r_clean   <= kts_pkg::NULL_BYTE;
            r_rep_idx <= r_idx;
            r_fnd     <= i_found[r_idx];
            r_end     <= i_found[r_idx] ? i_ends[r_idx] : '0;
            r_cnt     <= r_count;
            r_last    <= r_idx == last_idx;
        end
    end

    // run state is cleared once the last result of a run is loaded
    assign o_stat.busy     = r_busy;
    assign o_stat.out_free = out_free;
    assign o_stat.clear    = (run_end && i_active == '0) || rep_final;

    assign o_out_valid    = r_valid;
    assign o_kind         = r_kind;
    assign o_clean_byte   = r_clean;
    assign o_report_index = r_rep_idx;
    assign o_found        = r_fnd;
    assign o_match_end    = r_end;
    assign o_found_count  = r_cnt;
    assign o_last_result  = r_last;

endmodule

[hw/rtl/keyword_table_scanner_top.sv]
// ----------------------------------------------------------------------------
// keyword_table_scanner_top
// Multi-keyword substring search over a streamed byte buffer.
// ----------------------------------------------------------------------------
// Load up to eight keywords (a character beat per cell, a length beat per
// slot), set the number of active keywords, then stream buffer bytes. Every
// input beat passes an input register before it is handled; keyword beats
// are taken at one per clock outside the report sequence, and buffer bytes
// at one per clock when the output side also keeps up. Each byte's cleaned
// copy goes from the input register into the result register.
// The final byte of a buffer is followed on the output by one report beat per
// active keyword, one a cycle when the output side keeps up; the output
// register is shared by bytes and reports, so input stalls while a buffer's
// reports go out. There is no clearing pass after reset.
module keyword_table_scanner_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [kts_pkg::CNT_W-1:0]        i_cfg_wdata,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_func,
    input  logic [kts_pkg::SLOT_W-1:0]       i_kw_index,
    input  logic [kts_pkg::POS_W-1:0]        i_char_pos,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_last_item,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_kind,
    output logic [7:0]                       o_clean_byte,
    output logic [kts_pkg::SLOT_W-1:0]       o_report_index,
    output logic                             o_found,
    output logic [kts_pkg::BUF_W-1:0]        o_match_end,
    output logic [kts_pkg::CNT_W-1:0]        o_found_count,
    output logic                             o_last_result
);

    logic [kts_pkg::CNT_W-1:0]       r_active_keywords;
    logic [kts_pkg::CNT_W-1:0]       active;
    logic                            r_in_valid;
    logic [1:0]                      r_func;
    logic [kts_pkg::SLOT_W-1:0]      r_kw_index;
    logic [kts_pkg::POS_W-1:0]       r_char_pos;
    logic [7:0]                      r_data_byte;
    logic                            r_last_item;
    logic                            take;
    logic                            step;
    kts_pkg::t_kw_wr                 kw_wr;
    kts_pkg::t_rep_stat              stat;
    kts_pkg::t_kw_row                kw_chars [kts_pkg::NUM_KW];
    logic [kts_pkg::LEN_W-1:0]       kw_lens  [kts_pkg::NUM_KW];
    logic [kts_pkg::NUM_KW-1:0]      found;
    logic [kts_pkg::NUM_KW-1:0]      found_nxt;
    logic [kts_pkg::BUF_W-1:0]       ends [kts_pkg::NUM_KW];

    // active keyword register, clamped to the table size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_keywords <= '0;
        end else if (i_cfg_we) begin
            r_active_keywords <= i_cfg_wdata;
        end
    end

    assign active = (r_active_keywords > kts_pkg::CNT_W'(kts_pkg::NUM_KW)) ?
                    kts_pkg::CNT_W'(kts_pkg::NUM_KW) : r_active_keywords;

    // input register handoff: byte beats also need room in the result register
    assign take = r_in_valid && !stat.busy &&
                  (r_func != kts_pkg::FN_BYTE || stat.out_free);
    assign step = take && r_func == kts_pkg::FN_BYTE;
    assign o_in_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_func      <= i_func;
            r_kw_index  <= i_kw_index;
            r_char_pos  <= i_char_pos;
            r_data_byte <= i_data_byte;
            r_last_item <= i_last_item;
        end
    end

    // keyword table writes
    assign kw_wr.chr_we = take && r_func == kts_pkg::FN_CHAR;
    assign kw_wr.len_we = take && r_func == kts_pkg::FN_LEN;
    assign kw_wr.slot   = r_kw_index;
    assign kw_wr.pos    = r_char_pos;
    assign kw_wr.data   = r_data_byte;

    kts_kw_store u_kw_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (kw_wr),
        .o_chars (kw_chars),
        .o_lens  (kw_lens)
    );

    kts_match u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_clear     (stat.clear),
        .i_byte      (r_data_byte),
        .i_chars     (kw_chars),
        .i_lens      (kw_lens),
        .o_found     (found),
        .o_found_nxt (found_nxt),
        .o_ends      (ends)
    );

    kts_report u_report (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_byte         (r_data_byte),
        .i_last         (r_last_item),
        .i_active       (active),
        .i_found        (found),
        .i_found_nxt    (found_nxt),
        .i_ends         (ends),
        .i_out_ready    (i_out_ready),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_clean_byte   (o_clean_byte),
        .o_report_index (o_report_index),
        .o_found        (o_found),
        .o_match_end    (o_match_end),
        .o_found_count  (o_found_count),
        .o_last_result  (o_last_result)
    );

`ifndef SYNTHESIS
    // no byte is processed while reports are still going out
    a_no_step_in_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.busy && step))
        else $error("byte taken during report sequence");

    // a final byte with active keywords starts the report sequence
    a_reports_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_last_item && active != '0) |=> stat.busy)
        else $error("report sequence did not start");

    // a pending beat is held back while reports are going out
    a_stall_in_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.busy && r_in_valid) |-> !o_in_ready)
        else $error("input not stalled during reports");

    // a run only ends on a byte beat when no keyword is active
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_result && o_kind == kts_pkg::KIND_BYTE) |-> active == '0)
        else $error("byte beat closed a run with active keywords");

    // the run state is clear after the closing result is loaded
    a_clear_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clear |=> found == '0)
        else $error("found flags not cleared at end of run");
`endif

endmodule

[dv/tb_keyword_table_scanner_top.sv]
// ----------------------------------------------------------------------------
// tb_keyword_table_scanner_top
// Self-checking bench for the keyword table scanner. A short table of
// directed beats is followed by random keyword loads and buffers, a closing
// buffer whose keyword ends on the final byte, and random stalls on both
// channels. Every output beat is checked against an in-bench scanner model.
// ----------------------------------------------------------------------------
module tb_keyword_table_scanner_top;

    timeunit 1ns;
    timeprecision 1ps;

    // func code with no meaning to the block
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic                       kind;
        logic [7:0]                 clean;
        logic [kts_pkg::SLOT_W-1:0] idx;
        logic                       hit;
        logic [kts_pkg::BUF_W-1:0]  match_end;
        logic [kts_pkg::CNT_W-1:0]  cnt;
        logic                       last;
    } t_beat;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    // directed table row, the register value rides in data for ROW_CFG
    typedef struct packed {
        t_row_op                    op;
        logic [1:0]                 fn;
        logic [kts_pkg::SLOT_W-1:0] slot;
        logic [kts_pkg::POS_W-1:0]  pos;
        logic [7:0]                 data;
        logic                       last;
        logic                       pinned;
        logic [7:0]                 pinned_byte;
    } t_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [kts_pkg::CNT_W-1:0]    i_cfg_wdata = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic [1:0]                   i_func = '0;
    logic [kts_pkg::SLOT_W-1:0]   i_kw_index = '0;
    logic [kts_pkg::POS_W-1:0]    i_char_pos = '0;
    logic [7:0]                   i_data_byte = '0;
    logic                         i_last_item = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic                         o_kind;
    logic [7:0]                   o_clean_byte;
    logic [kts_pkg::SLOT_W-1:0]   o_report_index;
    logic                         o_found;
    logic [kts_pkg::BUF_W-1:0]    o_match_end;
    logic [kts_pkg::CNT_W-1:0]    o_found_count;
    logic                         o_last_result;

    // scanner model state
    bit [7:0]                     kw_chars [kts_pkg::NUM_KW][kts_pkg::KW_LEN];
    bit [kts_pkg::LEN_W-1:0]      kw_len [kts_pkg::NUM_KW];
    bit [7:0]                     window [kts_pkg::KW_LEN];
    bit [kts_pkg::BUF_W-1:0]      seen;
    bit                           hit_flag [kts_pkg::NUM_KW];
    bit [kts_pkg::BUF_W-1:0]      hit_end [kts_pkg::NUM_KW];
    bit [kts_pkg::CNT_W-1:0]      active_cfg;

    // characters written so far, random length changes never reach past these
    bit                           chr_known [kts_pkg::NUM_KW][kts_pkg::KW_LEN];

    t_beat                        step_beats [$];
    t_beat                        expected_beats [$];
    int                           mismatches;
    int                           beats_sent;
    int                           send_idle;
    int                           recv_idle;
    t_row                         dir_rows [0:22];

    keyword_table_scanner_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_kw_index     (i_kw_index),
        .i_char_pos     (i_char_pos),
        .i_data_byte    (i_data_byte),
        .i_last_item    (i_last_item),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_clean_byte   (o_clean_byte),
        .o_report_index (o_report_index),
        .o_found        (o_found),
        .o_match_end    (o_match_end),
        .o_found_count  (o_found_count),
        .o_last_result  (o_last_result)
    );

    always #2 i_clk = ~i_clk;

    // scanner model: fills step_beats with the beats one input beat causes
    function automatic void scan_item(input logic [1:0] fn, input logic [2:0] slot,
                                      input logic [3:0] pos, input logic [7:0] data,
                                      input logic last);
        t_beat beat;
        int    k;
        int    s;
        int    j;
        int    n_act;
        int    cnt;
        bit    same;
        step_beats.delete();
        case (fn)
            kts_pkg::FN_CHAR: begin
                kw_chars[slot][pos] = data;
            end
            kts_pkg::FN_LEN: begin
                kw_len[slot] = (data > kts_pkg::KW_LEN) ?
                               kts_pkg::LEN_W'(kts_pkg::KW_LEN) : data[kts_pkg::LEN_W-1:0];
            end
            kts_pkg::FN_BYTE: begin
                // shift window and count, saturating
                for (k = kts_pkg::KW_LEN - 1; k > 0; k--)
                    window[k] = window[k-1];
                window[0] = data;
                if (seen < kts_pkg::MAX_BUF_LEN)
                    seen++;
                // first match per keyword, empty keyword hits at offset zero
                for (s = 0; s < kts_pkg::NUM_KW; s++) begin
                    if (!hit_flag[s]) begin
                        if (kw_len[s] == 0) begin
                            hit_flag[s] = 1'b1;
                            hit_end[s]  = '0;
                        end else if (kw_len[s] <= seen) begin
                            same = 1'b1;
                            for (j = 0; j < kw_len[s]; j++)
                                if (kw_chars[s][j] != window[kw_len[s] - 1 - j])
                                    same = 1'b0;
                            if (same) begin
                                hit_flag[s] = 1'b1;
                                hit_end[s]  = seen;
                            end
                        end
                    end
                end
                n_act = (active_cfg > kts_pkg::NUM_KW) ? int'(kts_pkg::NUM_KW)
                                                       : int'(active_cfg);
                beat       = '0;
                beat.kind  = kts_pkg::KIND_BYTE;
                beat.clean = (data < kts_pkg::CTRL_LIMIT) ? kts_pkg::NULL_BYTE : data;
                beat.last  = last && (n_act == 0);
                step_beats.push_back(beat);
                if (last) begin
                    cnt = 0;
                    for (s = 0; s < n_act; s++)
                        if (hit_flag[s])
                            cnt++;
                    for (s = 0; s < n_act; s++) begin
                        beat           = '0;
                        beat.kind      = kts_pkg::KIND_REPORT;
                        beat.idx       = s[kts_pkg::SLOT_W-1:0];
                        beat.hit       = hit_flag[s];
                        beat.match_end = hit_flag[s] ? hit_end[s] : '0;
                        beat.cnt       = cnt[kts_pkg::CNT_W-1:0];
                        beat.last      = (s == n_act - 1);
                        step_beats.push_back(beat);
                    end
                    // run over, clear run state
                    for (k = 0; k < kts_pkg::KW_LEN; k++)
                        window[k] = '0;
                    for (s = 0; s < kts_pkg::NUM_KW; s++) begin
                        hit_flag[s] = 1'b0;
                        hit_end[s]  = '0;
                    end
                    seen = '0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int known_prefix(input int s);
        int n;
        n = 0;
        while (n < kts_pkg::KW_LEN && chr_known[s][n])
            n++;
        return n;
    endfunction

    // mostly a small alphabet so keywords hit, plus codes around the limit
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0, 1:    b = 8'h41 + 8'($urandom_range(0, 2));
            2:       b = 8'($urandom_range(0, 255));
            default: b = 8'($urandom_range(0, 30));
        endcase
        return b;
    endfunction

    // one input beat, with random gaps in front; returns at the accepting edge
    task automatic send_item(input logic [1:0] fn, input logic [2:0] slot,
                             input logic [3:0] pos, input logic [7:0] data,
                             input logic last, input bit pinned,
                             input logic [7:0] pinned_byte);
        t_beat pin_beat;
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= fn;
        i_kw_index  <= slot;
        i_char_pos  <= pos;
        i_data_byte <= data;
        i_last_item <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        scan_item(fn, slot, pos, data, last);
        if (pinned) begin
            pin_beat       = '0;
            pin_beat.kind  = kts_pkg::KIND_BYTE;
            pin_beat.clean = pinned_byte;
            expected_beats.push_back(pin_beat);
        end else begin
            foreach (step_beats[k])
                expected_beats.push_back(step_beats[k]);
        end
        if (fn == kts_pkg::FN_CHAR)
            chr_known[slot][pos] = 1'b1;
        if (fn != FN_UNUSED)
            beats_sent++;
    endtask

    // hold off the sender until every expected beat is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [kts_pkg::CNT_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        active_cfg = value;
        i_cfg_we   <= 1'b0;
    endtask

    // random keyword loads, buffers, stray writes and register changes
    task automatic random_traffic(input int n_items);
        int         start;
        int         pick;
        int         s;
        int         len;
        int         nb;
        int         k;
        int         p;
        logic [7:0] b;
        logic [7:0] inject [$];
        start = beats_sent;
        while (beats_sent - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                // load a whole keyword, short ones most of the time
                s   = $urandom_range(0, kts_pkg::NUM_KW - 1);
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, kts_pkg::KW_LEN)
                                                 : $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    send_item(kts_pkg::FN_CHAR, 3'(s), 4'(k), pick_byte(),
                              1'($urandom_range(0, 1)), 1'b0, 8'h00);
                if (len == kts_pkg::KW_LEN && $urandom_range(0, 1))
                    send_item(kts_pkg::FN_LEN, 3'(s), 4'($urandom_range(0, 15)),
                              8'($urandom_range(17, 255)), 1'($urandom_range(0, 1)),
                              1'b0, 8'h00);
                else
                    send_item(kts_pkg::FN_LEN, 3'(s), 4'($urandom_range(0, 15)), 8'(len),
                              1'($urandom_range(0, 1)), 1'b0, 8'h00);
            end else if (pick < 28) begin
                // stray char write or an unused func code
                send_item($urandom_range(0, 1) ? FN_UNUSED : kts_pkg::FN_CHAR,
                          3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'b0, 8'h00);
            end else if (pick < 32) begin
                // length change, may land inside an open buffer
                s = $urandom_range(0, kts_pkg::NUM_KW - 1);
                send_item(kts_pkg::FN_LEN, 3'(s), 4'($urandom_range(0, 15)),
                          8'($urandom_range(0, known_prefix(s))),
                          1'($urandom_range(0, 1)), 1'b0, 8'h00);
            end else if (pick < 36) begin
                if (seen == 0)
                    write_cfg(4'($urandom_range(0, 15)));
            end else if (pick < 39) begin
                wait_drained();
            end else begin
                // buffer bytes with keywords planted now and then
                nb = $urandom_range(1, 20);
                for (k = 0; k < nb; k++) begin
                    if (inject.size() == 0 && $urandom_range(0, 3) == 0) begin
                        s = $urandom_range(0, kts_pkg::NUM_KW - 1);
                        for (p = 0; p < kw_len[s]; p++)
                            inject.push_back(kw_chars[s][p]);
                    end
                    b = (inject.size() != 0) ? inject.pop_front() : pick_byte();
                    send_item(kts_pkg::FN_BYTE, 3'($urandom_range(0, 7)),
                              4'($urandom_range(0, 15)), b,
                              (k == nb - 1) && ($urandom_range(0, 3) != 0), 1'b0, 8'h00);
                end
                inject.delete();
            end
        end
    endtask

    // output side: check each beat and stall at random
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_kind, o_clean_byte, o_report_index, o_found, o_match_end,
                   o_found_count, o_last_result};
            if (expected_beats.size() == 0) begin
                $display({"%0t: expected none, actual kind=%0d byte=%02h idx=%0d",
                          " found=%0d end=%0d cnt=%0d last=%0d"},
                         $realtime, got.kind, got.clean, got.idx, got.hit,
                         got.match_end, got.cnt, got.last);
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                if (got !== want) begin
                    $display({"%0t: expected kind=%0d byte=%02h idx=%0d found=%0d",
                              " end=%0d cnt=%0d last=%0d"},
                             $realtime, want.kind, want.clean, want.idx, want.hit,
                             want.match_end, want.cnt, want.last);
                    $display({"%0t: actual   kind=%0d byte=%02h idx=%0d found=%0d",
                              " end=%0d cnt=%0d last=%0d"},
                             $realtime, got.kind, got.clean, got.idx, got.hit,
                             got.match_end, got.cnt, got.last);
                    mismatches++;
                end
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // run limit
    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int r;
        // directed beats: control codes, extremes, saturation, empty keyword,
        // match on the final byte, unused code and a mid-run length change
        dir_rows = '{
            '{ROW_ITEM, kts_pkg::FN_BYTE, 3'd0, 4'd0,  8'h00, 1'b0, 1'b1, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_BYTE, 3'd7, 4'd15, 8'h1A, 1'b0, 1'b1, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_BYTE, 3'd0, 4'd0,  8'h1B, 1'b0, 1'b1, 8'h1B},
            '{ROW_ITEM, kts_pkg::FN_BYTE, 3'd0, 4'd0,  8'hFF, 1'b1, 1'b0, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_CHAR, 3'd0, 4'd0,  8'h61, 1'b0, 1'b0, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_CHAR, 3'd0, 4'd1,  8'h62, 1'b1, 1'b0, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_LEN,  3'd0, 4'd0,  8'hC8, 1'b0, 1'b0, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_LEN,  3'd0, 4'd15, 8'h02, 1'b0, 1'b0, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_CHAR, 3'd7, 4'd15, 8'hFF, 1'b0, 1'b0, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_LEN,  3'd1, 4'd0,  8'h00, 1'b1, 1'b0, 8'h00},
            '{ROW_ITEM, FN_UNUSED,        3'd7, 4'd15, 8'hFF, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  kts_pkg::FN_CHAR, 3'd0, 4'd0,  8'h0F, 1'b0, 1'b0, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_BYTE, 3'd0, 4'd0,  8'h78, 1'b0, 1'b1, 8'h78},
            '{ROW_ITEM, kts_pkg::FN_BYTE, 3'd0, 4'd0,  8'h61, 1'b0, 1'b1, 8'h61},
            '{ROW_ITEM, kts_pkg::FN_BYTE, 3'd0, 4'd0,  8'h62, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  kts_pkg::FN_CHAR, 3'd0, 4'd0,  8'h01, 1'b0, 1'b0, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_BYTE, 3'd0, 4'd0,  8'h61, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  kts_pkg::FN_CHAR, 3'd0, 4'd0,  8'h08, 1'b0, 1'b0, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_BYTE, 3'd0, 4'd0,  8'h10, 1'b0, 1'b1, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_LEN,  3'd0, 4'd0,  8'h01, 1'b0, 1'b0, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_BYTE, 3'd0, 4'd0,  8'h61, 1'b0, 1'b0, 8'h00},
            '{ROW_ITEM, kts_pkg::FN_BYTE, 3'd0, 4'd0,  8'h62, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  kts_pkg::FN_CHAR, 3'd0, 4'd0,  8'h00, 1'b0, 1'b0, 8'h00}
        };

        send_idle = 6;
        recv_idle = 70;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].op == ROW_CFG)
                write_cfg(dir_rows[k].data[kts_pkg::CNT_W-1:0]);
            else
                send_item(dir_rows[k].fn, dir_rows[k].slot, dir_rows[k].pos,
                          dir_rows[k].data, dir_rows[k].last, dir_rows[k].pinned,
                          dir_rows[k].pinned_byte);
        end

        random_traffic(100);
        send_idle = 70;
        recv_idle = 6;
        random_traffic(100);
        send_idle = 0;
        recv_idle = 0;
        random_traffic(100);

        // closing buffer: the keyword hits only on the very last byte
        if (seen != 0)
            send_item(kts_pkg::FN_BYTE, 3'd0, 4'd0, 8'h20, 1'b1, 1'b0, 8'h00);
        send_item(kts_pkg::FN_CHAR, 3'd0, 4'd0, 8'h61, 1'b0, 1'b0, 8'h00);
        send_item(kts_pkg::FN_CHAR, 3'd0, 4'd1, 8'h62, 1'b0, 1'b0, 8'h00);
        send_item(kts_pkg::FN_LEN, 3'd0, 4'd0, 8'h02, 1'b0, 1'b0, 8'h00);
        write_cfg(4'd8);
        for (r = 0; r < 6; r++)
            send_item(kts_pkg::FN_BYTE, 3'($urandom_range(0, 7)),
                      4'($urandom_range(0, 15)), 8'($urandom_range(0, 8'h5F)),
                      1'b0, 1'b0, 8'h00);
        send_item(kts_pkg::FN_BYTE, 3'd0, 4'd0, 8'h61, 1'b0, 1'b0, 8'h00);
        send_item(kts_pkg::FN_BYTE, 3'd0, 4'd0, 8'h62, 1'b1, 1'b0, 8'h00);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/kts_pkg.sv
hw/rtl/kts_kw_store.sv
hw/rtl/kts_match.sv
hw/rtl/kts_report.sv
hw/rtl/keyword_table_scanner_top.sv
dv/tb_keyword_table_scanner_top.sv
